// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for concurrent checks, clocked and reset-qualified.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising edge outside reset.
`define PVM_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Implication checked in the same cycle.
`define PVM_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication checked in the cycle after the antecedent.
`define PVM_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/pvm_pkg.sv -----
// ----------------------------------------------------------------------------
// pvm_pkg
// Types, codes and helpers shared by the voice mixer modules.
// ----------------------------------------------------------------------------
package pvm_pkg;

    // Default sizes
    localparam int PVM_NUM_CLIPS         = 16;
    localparam int PVM_NUM_EFFECT_VOICES = 4;
    localparam int PVM_SAMPLE_WORDS      = 65536;
    localparam int PVM_QUEUE_DEPTH       = 2;

    // Input function codes
    localparam logic [2:0] FUNC_TICK       = 3'd0;
    localparam logic [2:0] FUNC_PLAY_FX    = 3'd1;
    localparam logic [2:0] FUNC_PLAY_TITLE = 3'd2;
    localparam logic [2:0] FUNC_STOP_TITLE = 3'd3;
    localparam logic [2:0] FUNC_STOP_ALL   = 3'd4;
    localparam logic [2:0] FUNC_WRITE      = 3'd5;
    localparam logic [2:0] FUNC_DEFINE     = 3'd6;

    // Command codes carried through the queue
    localparam logic [2:0] CMD_TICK       = 3'd0;
    localparam logic [2:0] CMD_PLAY_FX    = 3'd1;
    localparam logic [2:0] CMD_PLAY_TITLE = 3'd2;
    localparam logic [2:0] CMD_STOP_TITLE = 3'd3;
    localparam logic [2:0] CMD_STOP_ALL   = 3'd4;
    localparam logic [2:0] CMD_WRITE      = 3'd5;

    // Configuration register indexes
    localparam logic [1:0] CFG_READY       = 2'd0;
    localparam logic [1:0] CFG_TITLE_START = 2'd1;
    localparam logic [1:0] CFG_TITLE_LEN   = 2'd2;

    localparam logic signed [15:0] SAT_MAX = 16'sd32767;
    localparam logic signed [15:0] SAT_MIN = -16'sd32768;

    // Classified command; start doubles as write address, data as sample
    typedef struct packed {
        logic [2:0]  op;
        logic [15:0] start;
        logic [16:0] len;
        logic        loops;
        logic [15:0] data;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    function automatic logic signed [15:0] sat_add(input logic signed [15:0] a,
                                                   input logic signed [15:0] b);
        logic signed [16:0] s;
        s = 17'(a) + 17'(b);
        if (s > 17'(SAT_MAX)) begin
            return SAT_MAX;
        end else if (s < 17'(SAT_MIN)) begin
            return SAT_MIN;
        end
        return s[15:0];
    endfunction

endpackage

// ----- rtl/pvm_queue.sv -----
// ----------------------------------------------------------------------------
// pvm_queue
// Small command FIFO between the front and back ends.
// ----------------------------------------------------------------------------
module pvm_queue
    import pvm_pkg::*;
#(
    parameter int DEPTH = PVM_QUEUE_DEPTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_cmd      i_cmd,
    input  logic      i_pop,
    output t_cmd      o_cmd,
    output t_q_status o_status
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_cmd          r_buf [DEPTH];
    logic [PW-1:0] r_wp;
    logic [PW-1:0] r_rp;
    logic [CW-1:0] r_cnt;
    logic          do_push;
    logic          do_pop;

    assign o_status.full  = (r_cnt == CW'(DEPTH));
    assign o_status.empty = (r_cnt == '0);
    assign do_push = i_push && !o_status.full;
    assign do_pop  = i_pop && !o_status.empty;
    assign o_cmd   = r_buf[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_buf[r_wp] <= i_cmd;
        end
    end

endmodule

// ----- rtl/pvm_front.sv -----
// ----------------------------------------------------------------------------
// pvm_front
// Accepts items, holds configuration and the clip table, classifies commands.
// ----------------------------------------------------------------------------
module pvm_front
    import pvm_pkg::*;
#(
    parameter int NUM_CLIPS = PVM_NUM_CLIPS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [2:0]         i_func,
    input  logic [3:0]         i_clip_id,
    input  logic               i_sounds_on,
    input  logic               i_walk_beep_on,
    input  logic               i_loop_title,
    input  logic [15:0]        i_address,
    input  logic signed [15:0] i_sample_value,
    input  logic [16:0]        i_clip_length,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [16:0]        i_cfg_data,
    input  t_q_status          i_q_status,
    output logic               o_push,
    output t_cmd               o_cmd
);

    // Only ids that fit the 4-bit field can ever be addressed
    localparam int CS  = (NUM_CLIPS < 16) ? NUM_CLIPS : 16;
    localparam int CIW = (CS > 1) ? $clog2(CS) : 1;

    logic          r_ready;
    logic [15:0]   r_title_start;
    logic [16:0]   r_title_len;
    logic [15:0]   r_clip_start [CS];
    logic [16:0]   r_clip_len   [CS];

    logic           accept;
    logic           id_ok;
    logic           fx_en;
    logic [CIW-1:0] cidx;
    logic           def_we;

    assign o_stall = i_q_status.full;
    assign accept  = i_valid && !i_q_status.full;
    assign id_ok   = (32'(i_clip_id) < 32'(NUM_CLIPS));
    assign fx_en   = (i_clip_id == 4'd0) ? i_walk_beep_on : i_sounds_on;
    assign cidx    = CIW'(i_clip_id);
    assign def_we  = accept && (i_func == FUNC_DEFINE) && id_ok;

    always_comb begin
        o_push      = 1'b0;
        o_cmd.op    = CMD_TICK;
        o_cmd.start = i_address;
        o_cmd.len   = '0;
        o_cmd.loops = 1'b0;
        o_cmd.data  = i_sample_value;
        case (i_func)
            FUNC_TICK: begin
                o_push = accept;
            end
            FUNC_PLAY_FX: begin
                o_cmd.op = CMD_PLAY_FX;
                if (id_ok) begin
                    o_cmd.start = r_clip_start[cidx];
                    o_cmd.len   = r_clip_len[cidx];
                end
                o_push = accept && r_ready && id_ok && fx_en && (o_cmd.len != '0);
            end
            FUNC_PLAY_TITLE: begin
                o_cmd.op    = CMD_PLAY_TITLE;
                o_cmd.start = r_title_start;
                o_cmd.len   = r_title_len;
                o_cmd.loops = i_loop_title;
                o_push      = accept && r_ready && (r_title_len != '0);
            end
            FUNC_STOP_TITLE: begin
                o_cmd.op = CMD_STOP_TITLE;
                o_push   = accept && r_ready;
            end
            FUNC_STOP_ALL: begin
                o_cmd.op = CMD_STOP_ALL;
                o_push   = accept && r_ready;
            end
            FUNC_WRITE: begin
                o_cmd.op = CMD_WRITE;
                o_push   = accept;
            end
            default: begin
                // clip definitions stay here; unused codes drop
                o_push = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ready       <= 1'b0;
            r_title_start <= '0;
            r_title_len   <= '0;
            for (int k = 0; k < CS; k++) begin
                r_clip_start[k] <= '0;
                r_clip_len[k]   <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_READY:       r_ready       <= i_cfg_data[0];
                    CFG_TITLE_START: r_title_start <= i_cfg_data[15:0];
                    CFG_TITLE_LEN:   r_title_len   <= i_cfg_data;
                    default:         ;
                endcase
            end
            if (def_we) begin
                r_clip_start[cidx] <= i_address;
                r_clip_len[cidx]   <= i_clip_length;
            end
        end
    end

endmodule

// ----- rtl/pvm_back.sv -----
// ----------------------------------------------------------------------------
// pvm_back
// Voice state, sample memory and the mixing pipeline with result register.
// ----------------------------------------------------------------------------
module pvm_back
    import pvm_pkg::*;
#(
    parameter int NUM_EFFECT_VOICES = PVM_NUM_EFFECT_VOICES,
    parameter int SAMPLE_WORDS      = PVM_SAMPLE_WORDS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    input  t_q_status          i_q_status,
    output logic               o_pop,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [15:0] o_mixed_sample,
    output logic               o_music_active,
    output logic [3:0]         o_effects_active
);

    localparam int NV  = 1 + NUM_EFFECT_VOICES;
    localparam int VW  = $clog2(NV);
    localparam int XW  = 18;                       // start + position
    localparam int AW  = $clog2(SAMPLE_WORDS);
    localparam int NB  = AW + 1;
    localparam int RW  = XW + 2;
    localparam int K   = XW + AW;
    localparam int MW  = (NB > XW) ? NB : XW;
    localparam logic [RW-1:0] RECIP  = RW'((64'd1 << K) / 64'(SAMPLE_WORDS));
    localparam logic [NB-1:0] N_WORD = NB'(SAMPLE_WORDS);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_ISSUE = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;

    logic [1:0]    r_state;
    logic [VW-1:0] r_vidx;

    logic [15:0]   r_v_start [NV];
    logic [16:0]   r_v_len   [NV];
    logic [16:0]   r_v_pos   [NV];
    logic          r_v_act   [NV];
    logic          r_v_loop  [NV];

    // address reduction and memory pipeline
    logic          r_s1_vld, r_s1_wr;
    logic [XW-1:0] r_s1_x;
    logic [15:0]   r_s1_data;
    logic          r_s2_vld, r_s2_wr;
    logic [XW-1:0] r_s2_x, r_s2_q;
    logic [15:0]   r_s2_data;
    logic          r_s3_vld, r_s3_wr;
    logic [XW-1:0] r_s3_x, r_s3_prod;
    logic [15:0]   r_s3_data;
    logic          r_s4_add;
    logic signed [15:0] r_rdata;
    logic signed [15:0] r_acc;

    logic [15:0]   mem [SAMPLE_WORDS];

    logic               r_o_valid;
    logic signed [15:0] r_o_mix;
    logic               r_o_music;
    logic [3:0]         r_o_fx;

    logic          step_add, step_clear;
    logic [16:0]   step_p;
    logic [XW-1:0] step_x;
    logic [VW-1:0] free_slot;
    logic          n_s1_vld, n_s1_wr;
    logic [XW-1:0] n_s1_x;
    logic [15:0]   n_s1_data;
    logic [XW+RW-1:0] recip_prod;
    logic [MW-1:0] res0, res1;
    logic [AW-1:0] mem_idx;
    logic          pipe_busy;
    logic          out_free;
    logic          res_load;
    logic [3:0]    fx_bits;

    // Advance the voice under r_vidx by one sample, or retire it at its end
    always_comb begin
        step_add   = 1'b0;
        step_clear = 1'b0;
        step_p     = r_v_pos[r_vidx];
        if (r_v_act[r_vidx] && (r_v_len[r_vidx] != '0)) begin
            if (r_v_pos[r_vidx] >= r_v_len[r_vidx]) begin
                if (r_v_loop[r_vidx]) begin
                    step_p   = '0;
                    step_add = 1'b1;
                end else begin
                    step_clear = 1'b1;
                end
            end else begin
                step_add = 1'b1;
            end
        end
        step_x = XW'(r_v_start[r_vidx]) + XW'(step_p);
    end

    // First idle effect voice, else the first effect voice
    always_comb begin
        free_slot = VW'(1);
        for (int k = NV - 1; k >= 1; k--) begin
            if (!r_v_act[k]) begin
                free_slot = VW'(k);
            end
        end
    end

    assign o_pop = (r_state == ST_IDLE) && !i_q_status.empty;

    always_comb begin
        n_s1_vld  = 1'b0;
        n_s1_wr   = 1'b0;
        n_s1_x    = step_x;
        n_s1_data = i_cmd.data;
        if (o_pop && (i_cmd.op == CMD_WRITE)) begin
            n_s1_vld = 1'b1;
            n_s1_wr  = 1'b1;
            n_s1_x   = XW'(i_cmd.start);
        end else if (r_state == ST_ISSUE) begin
            n_s1_vld = step_add;
        end
    end

    assign recip_prod = {{RW{1'b0}}, r_s1_x} * {{XW{1'b0}}, RECIP};
    assign res0    = MW'(r_s3_x) - MW'(r_s3_prod);
    assign res1    = (res0 >= MW'(N_WORD)) ? res0 - MW'(N_WORD) : res0;
    assign mem_idx = AW'(res1);

    assign pipe_busy = r_s1_vld || r_s2_vld || r_s3_vld || r_s4_add;
    assign out_free  = !r_o_valid || !i_stall;
    assign res_load  = (r_state == ST_DRAIN) && !pipe_busy && out_free;

    always_comb begin
        fx_bits = '0;
        for (int k = 0; k < 4; k++) begin
            if (k < NUM_EFFECT_VOICES) begin
                fx_bits[k] = r_v_act[k + 1];
            end
        end
    end

    // Control, voice state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_vidx    <= '0;
            r_o_valid <= 1'b0;
            for (int k = 0; k < NV; k++) begin
                r_v_act[k] <= 1'b0;
            end
        end else begin
            if (r_o_valid && !i_stall && !res_load) begin
                r_o_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (o_pop) begin
                        case (i_cmd.op)
                            CMD_TICK: begin
                                r_vidx  <= '0;
                                r_state <= ST_ISSUE;
                            end
                            CMD_PLAY_FX: begin
                                r_v_start[free_slot] <= i_cmd.start;
                                r_v_len[free_slot]   <= i_cmd.len;
                                r_v_pos[free_slot]   <= '0;
                                r_v_loop[free_slot]  <= 1'b0;
                                r_v_act[free_slot]   <= 1'b1;
                            end
                            CMD_PLAY_TITLE: begin
                                r_v_start[0] <= i_cmd.start;
                                r_v_len[0]   <= i_cmd.len;
                                r_v_pos[0]   <= '0;
                                r_v_loop[0]  <= i_cmd.loops;
                                r_v_act[0]   <= 1'b1;
                            end
                            CMD_STOP_TITLE: begin
                                r_v_act[0] <= 1'b0;
                                r_v_len[0] <= '0;
                                r_v_pos[0] <= '0;
                            end
                            CMD_STOP_ALL: begin
                                for (int k = 0; k < NV; k++) begin
                                    r_v_act[k] <= 1'b0;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                ST_ISSUE: begin
                    if (step_add) begin
                        r_v_pos[r_vidx] <= step_p + 1'b1;
                    end
                    if (step_clear) begin
                        r_v_act[r_vidx] <= 1'b0;
                    end
                    if (r_vidx == VW'(NV - 1)) begin
                        r_state <= ST_DRAIN;
                    end else begin
                        r_vidx <= r_vidx + 1'b1;
                    end
                end
                ST_DRAIN: begin
                    if (res_load) begin
                        r_o_valid <= 1'b1;
                        r_o_mix   <= r_acc;
                        r_o_music <= r_v_act[0];
                        r_o_fx    <= fx_bits;
                        r_state   <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // Pipeline valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
            r_s4_add <= 1'b0;
        end else begin
            r_s1_vld <= n_s1_vld;
            r_s2_vld <= r_s1_vld;
            r_s3_vld <= r_s2_vld;
            r_s4_add <= r_s3_vld && !r_s3_wr;
        end
    end

    // Pipeline payload: reciprocal quotient, back-multiply, memory access
    always_ff @(posedge i_clk) begin
        r_s1_wr   <= n_s1_wr;
        r_s1_x    <= n_s1_x;
        r_s1_data <= n_s1_data;
        r_s2_wr   <= r_s1_wr;
        r_s2_x    <= r_s1_x;
        r_s2_data <= r_s1_data;
        r_s2_q    <= XW'(recip_prod >> K);
        r_s3_wr   <= r_s2_wr;
        r_s3_x    <= r_s2_x;
        r_s3_data <= r_s2_data;
        r_s3_prod <= XW'({{NB{1'b0}}, r_s2_q} * {{XW{1'b0}}, N_WORD});
    end

    // Accumulate with saturation; clear as a tick leaves the queue
    always_ff @(posedge i_clk) begin
        if (o_pop && (i_cmd.op == CMD_TICK)) begin
            r_acc <= '0;
        end else if (r_s4_add) begin
            r_acc <= sat_add(r_acc, r_rdata);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s3_vld && r_s3_wr) begin
            mem[mem_idx] <= r_s3_data;
        end else if (r_s3_vld) begin
            r_rdata <= mem[mem_idx];
        end
    end

    assign o_valid          = r_o_valid;
    assign o_mixed_sample   = r_o_mix;
    assign o_music_active   = r_o_music;
    assign o_effects_active = r_o_fx;

endmodule

// ----- rtl/pcm_voice_mixer.sv -----
// ----------------------------------------------------------------------------
// pcm_voice_mixer
// Mono 16-bit sample playback mixer: one music voice, several effect voices.
// ----------------------------------------------------------------------------
// Each accepted item is classified at once by the front end (clip look-up,
// enable and armed checks, clip definitions, configuration) and, if it has
// work left, queued for the back end. The back end takes one command at a
// time: play, stop and sample writes are executed from the idle state; a tick
// walks the voices one per cycle through a four-stage address-reduction and
// memory pipeline, then waits for the pipeline to drain and the output
// register to be free. The result waits in an output register while the
// next command proceeds, and input items keep being taken while the queue
// has room. Only a tick gives a result; sample memory contents are undefined
// until written.
// ----------------------------------------------------------------------------
module pcm_voice_mixer
    import pvm_pkg::*;
#(
    parameter int NUM_CLIPS         = PVM_NUM_CLIPS,
    parameter int NUM_EFFECT_VOICES = PVM_NUM_EFFECT_VOICES,
    parameter int SAMPLE_WORDS      = PVM_SAMPLE_WORDS,
    parameter int QUEUE_DEPTH       = PVM_QUEUE_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // input channel
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [2:0]         i_func,
    input  logic [3:0]         i_clip_id,
    input  logic               i_sounds_on,
    input  logic               i_walk_beep_on,
    input  logic               i_loop_title,
    input  logic [15:0]        i_address,
    input  logic signed [15:0] i_sample_value,
    input  logic [16:0]        i_clip_length,
    // configuration write port
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [16:0]        i_cfg_data,
    // result channel
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [15:0] o_mixed_sample,
    output logic               o_music_active,
    output logic [3:0]         o_effects_active
);

    t_cmd      front_cmd;
    t_cmd      head_cmd;
    t_q_status q_status;
    logic      push;
    logic      pop;

    // Classify each transaction; drop those with nothing left to do
    pvm_front #(
        .NUM_CLIPS (NUM_CLIPS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_func         (i_func),
        .i_clip_id      (i_clip_id),
        .i_sounds_on    (i_sounds_on),
        .i_walk_beep_on (i_walk_beep_on),
        .i_loop_title   (i_loop_title),
        .i_address      (i_address),
        .i_sample_value (i_sample_value),
        .i_clip_length  (i_clip_length),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_q_status     (q_status),
        .o_push         (push),
        .o_cmd          (front_cmd)
    );

    // Hold commands so either side may stall on its own
    pvm_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_cmd    (front_cmd),
        .i_pop    (pop),
        .o_cmd    (head_cmd),
        .o_status (q_status)
    );

    // Execute commands, mix ticks, present results
    pvm_back #(
        .NUM_EFFECT_VOICES (NUM_EFFECT_VOICES),
        .SAMPLE_WORDS      (SAMPLE_WORDS)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (head_cmd),
        .i_q_status       (q_status),
        .o_pop            (pop),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_mixed_sample   (o_mixed_sample),
        .o_music_active   (o_music_active),
        .o_effects_active (o_effects_active)
    );

endmodule

// ----- rtl/pvm_checker.sv -----
// ----------------------------------------------------------------------------
// pvm_checker
// Port-level checks on the mixer, attached to the top level by bind.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pvm_checker
    import pvm_pkg::*;
#(
    parameter int NUM_EFFECT_VOICES = PVM_NUM_EFFECT_VOICES
) (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic               o_stall,
    input logic [2:0]         i_func,
    input logic               o_valid,
    input logic               i_stall,
    input logic signed [15:0] o_mixed_sample,
    input logic               o_music_active,
    input logic [3:0]         o_effects_active
);

    logic [7:0] r_pend;
    logic [7:0] n_pend;
    logic       tick_in;
    logic       res_out;

    assign tick_in = i_valid && !o_stall && (i_func == FUNC_TICK);
    assign res_out = o_valid && !i_stall;

    // Count ticks taken whose result has not yet been delivered
    always_comb begin
        n_pend = r_pend;
        if (tick_in && !res_out) begin
            n_pend = r_pend + 1'b1;
        end else if (res_out && !tick_in) begin
            n_pend = r_pend - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
        end else begin
            r_pend <= n_pend;
        end
    end

    `PVM_ASSERT_IMP(a_result_has_tick, i_clk, i_rst_n, o_valid, r_pend != 8'd0, "result without a pending tick")
    `PVM_ASSERT_NXT(a_result_holds, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_mixed_sample) && $stable(o_music_active) && $stable(o_effects_active), "stalled result changed")
    `PVM_ASSERT_IMP(a_fx_bits_in_range, i_clk, i_rst_n, o_valid, (o_effects_active >> NUM_EFFECT_VOICES) == 4'd0, "effect bit set for absent voice")

endmodule

bind pcm_voice_mixer pvm_checker #(
    .NUM_EFFECT_VOICES (NUM_EFFECT_VOICES)
) u_pvm_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_valid          (i_valid),
    .o_stall          (o_stall),
    .i_func           (i_func),
    .o_valid          (o_valid),
    .i_stall          (i_stall),
    .o_mixed_sample   (o_mixed_sample),
    .o_music_active   (o_music_active),
    .o_effects_active (o_effects_active)
);
